@@ design/ry420_pkg.sv @@
// ----------------------------------------------------------------------------
// ry420_pkg: shared types, constants and helpers for the RGB to YCbCr block
// Holds the request/response beat structs, the BT.601 integer coefficients
// and the reciprocal constants used for the constant divisions.
// ----------------------------------------------------------------------------
package ry420_pkg;

   typedef struct packed {
      logic [23:0] top_left_pixel;
      logic [23:0] top_right_pixel;
      logic [23:0] bottom_left_pixel;
      logic [23:0] bottom_right_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } rsp_type;

   // One pixel split into channels.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   localparam int NUM_LANES = 4;
   localparam int PIPE_DEPTH = 4;

   // Luma: (98B + 504G + 257R + 16500) / 1000
   localparam int LUMA_NUM_W = 18;
   localparam logic [LUMA_NUM_W-1:0] LUMA_CB = 18'd98;
   localparam logic [LUMA_NUM_W-1:0] LUMA_CG = 18'd504;
   localparam logic [LUMA_NUM_W-1:0] LUMA_CR = 18'd257;
   localparam logic [LUMA_NUM_W-1:0] LUMA_OFS = 18'd16500;
   // ceil(2^28 / 1000); exact floor for numerators below 2^18
   localparam int LUMA_SHIFT = 28;
   localparam int LUMA_RECIP_W = 19;
   localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;
   localparam int LUMA_PROD_W = LUMA_NUM_W + LUMA_RECIP_W;

   // Chroma over 10-bit channel sums, divided by 4000
   localparam int SUM_W = 10;
   localparam int CHROMA_NUM_W = 20;
   localparam logic [CHROMA_NUM_W-1:0] CB_KB = 20'd439;
   localparam logic [CHROMA_NUM_W-1:0] CB_KG = 20'd291;
   localparam logic [CHROMA_NUM_W-1:0] CB_KR = 20'd148;
   localparam logic [CHROMA_NUM_W-1:0] CR_KB = 20'd71;
   localparam logic [CHROMA_NUM_W-1:0] CR_KG = 20'd368;
   localparam logic [CHROMA_NUM_W-1:0] CR_KR = 20'd439;
   localparam logic [CHROMA_NUM_W-1:0] CHROMA_OFS = 20'd514000;
   // ceil(2^32 / 4000); exact floor for numerators below 2^20
   localparam int CHROMA_SHIFT = 32;
   localparam int CHROMA_RECIP_W = 21;
   localparam logic [CHROMA_RECIP_W-1:0] CHROMA_RECIP = 21'd1073742;
   localparam int CHROMA_PROD_W = CHROMA_NUM_W + CHROMA_RECIP_W;

   localparam logic [8:0] LUMA_MIN = 9'd16;
   localparam logic [8:0] LUMA_MAX = 9'd235;
   localparam logic [8:0] CHROMA_MIN = 9'd16;
   localparam logic [8:0] CHROMA_MAX = 9'd240;

   function automatic logic [7:0] clamp8(input logic [8:0] v,
                                         input logic [8:0] lo,
                                         input logic [8:0] hi);
      logic [8:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r[7:0];
   endfunction

endpackage

@@ design/rgb_to_yuv420_block_top.sv @@
// ----------------------------------------------------------------------------
// rgb_to_yuv420_block_top: BT.601 RGB to YCbCr 4:2:0 for one 2x2 block
// A block passes the lane sum, multiply and clamp registers (merge numerator
// and product in parallel), then rsp_ff; rsp_strobe is high for one cycle.
// Throughput: one block per cycle; busy is never raised, as the receiver
// cannot stall and the pipeline holds no state between blocks.
// Reset clears only the valid pipeline, so no stale strobe follows reset.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_block_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ry420_pkg::req_type  req_data,
   output logic                rsp_strobe,
   output ry420_pkg::rsp_type  rsp_data
);

   // Lane order follows the beat: top left, top right, bottom left, bottom right.
   logic [23:0]          lane_pixel [ry420_pkg::NUM_LANES];
   ry420_pkg::pixel_type lane_pix   [ry420_pkg::NUM_LANES];
   logic [7:0]           lane_luma  [ry420_pkg::NUM_LANES];

   logic [ry420_pkg::CHROMA_PROD_W-1:0] cb_prod, cr_prod;

   logic [ry420_pkg::PIPE_DEPTH-1:0] valid_in, valid_ff;
   ry420_pkg::rsp_type               rsp_in, rsp_ff;
   logic                             accept;

   // The pipeline never backs up, so take a beat every cycle.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign lane_pixel[0] = req_data.top_left_pixel;
   assign lane_pixel[1] = req_data.top_right_pixel;
   assign lane_pixel[2] = req_data.bottom_left_pixel;
   assign lane_pixel[3] = req_data.bottom_right_pixel;

   // Four luma lanes side by side, one per pixel of the block.
   for (genvar i = 0; i < ry420_pkg::NUM_LANES; i++) begin : g_lane
      ry420_luma_lane u_lane (
         .clock   (clock),
         .pixel   (lane_pixel[i]),
         .pix_out (lane_pix[i]),
         .luma    (lane_luma[i])
      );
   end

   // Merge the lanes' pixels into the shared chroma pair.
   ry420_chroma_merge u_merge (
      .clock   (clock),
      .pix     (lane_pix),
      .cb_prod (cb_prod),
      .cr_prod (cr_prod)
   );

   always_comb begin
      // Advance the valid marks alongside the data stages.
      valid_in = {valid_ff[ry420_pkg::PIPE_DEPTH-2:0], accept};
      // Lane luma and merge products arrive in the same stage; floor and
      // clamp chroma here and register the whole beat.
      rsp_in.luma_top_left     = lane_luma[0];
      rsp_in.luma_top_right    = lane_luma[1];
      rsp_in.luma_bottom_left  = lane_luma[2];
      rsp_in.luma_bottom_right = lane_luma[3];
      rsp_in.chroma_blue = ry420_pkg::clamp8(
         cb_prod[ry420_pkg::CHROMA_SHIFT+8:ry420_pkg::CHROMA_SHIFT],
         ry420_pkg::CHROMA_MIN, ry420_pkg::CHROMA_MAX);
      rsp_in.chroma_red = ry420_pkg::clamp8(
         cr_prod[ry420_pkg::CHROMA_SHIFT+8:ry420_pkg::CHROMA_SHIFT],
         ry420_pkg::CHROMA_MIN, ry420_pkg::CHROMA_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset; the strobe qualifies it.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = valid_ff[ry420_pkg::PIPE_DEPTH-1];
   assign rsp_data   = rsp_ff;

endmodule

@@ design/ry420_luma_lane.sv @@
// ----------------------------------------------------------------------------
// ry420_luma_lane: per-pixel luma lane
// Three-stage lane: weighted sum, reciprocal multiply, floor and clamp.
// Also passes its split pixel to the chroma merge stage.
// ----------------------------------------------------------------------------
module ry420_luma_lane (
   input  logic                  clock,
   input  logic [23:0]           pixel,
   output ry420_pkg::pixel_type  pix_out,
   output logic [7:0]            luma
);

   ry420_pkg::pixel_type                    pix_in, pix_ff;
   logic [ry420_pkg::LUMA_NUM_W-1:0]        num_in, num_ff;
   logic [ry420_pkg::LUMA_PROD_W-1:0]       prod_in, prod_ff;
   logic [7:0]                              luma_in, luma_ff;

   always_comb begin
      pix_in = ry420_pkg::pixel_type'(pixel);
      num_in = ry420_pkg::LUMA_CB * {10'd0, pix_in.blue}
             + ry420_pkg::LUMA_CG * {10'd0, pix_in.green}
             + ry420_pkg::LUMA_CR * {10'd0, pix_in.red}
             + ry420_pkg::LUMA_OFS;
      prod_in = ry420_pkg::LUMA_PROD_W'(num_ff)
              * ry420_pkg::LUMA_PROD_W'(ry420_pkg::LUMA_RECIP);
      luma_in = ry420_pkg::clamp8(
                   prod_ff[ry420_pkg::LUMA_SHIFT+8:ry420_pkg::LUMA_SHIFT],
                   ry420_pkg::LUMA_MIN, ry420_pkg::LUMA_MAX);
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      luma_ff <= luma_in;
   end

   assign pix_out = pix_ff;
   assign luma    = luma_ff;

endmodule

@@ design/ry420_chroma_merge.sv @@
// ----------------------------------------------------------------------------
// ry420_chroma_merge: block chroma from the four lanes
// Sums the channels over the lanes and forms the Cb/Cr numerators, then
// multiplies by the reciprocal of 4000. Clamping happens in the top module.
// ----------------------------------------------------------------------------
module ry420_chroma_merge (
   input  logic                                 clock,
   input  ry420_pkg::pixel_type                 pix [ry420_pkg::NUM_LANES],
   output logic [ry420_pkg::CHROMA_PROD_W-1:0]  cb_prod,
   output logic [ry420_pkg::CHROMA_PROD_W-1:0]  cr_prod
);

   logic [ry420_pkg::SUM_W-1:0]          sum_r, sum_g, sum_b;
   logic [ry420_pkg::CHROMA_NUM_W-1:0]   sr, sg, sb;
   logic [ry420_pkg::CHROMA_NUM_W-1:0]   cb_num_in, cb_num_ff, cr_num_in, cr_num_ff;
   logic [ry420_pkg::CHROMA_PROD_W-1:0]  cb_prod_in, cb_prod_ff, cr_prod_in, cr_prod_ff;

   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int i = 0; i < ry420_pkg::NUM_LANES; i++) begin
         sum_r = sum_r + {2'd0, pix[i].red};
         sum_g = sum_g + {2'd0, pix[i].green};
         sum_b = sum_b + {2'd0, pix[i].blue};
      end
      sr = ry420_pkg::CHROMA_NUM_W'(sum_r);
      sg = ry420_pkg::CHROMA_NUM_W'(sum_g);
      sb = ry420_pkg::CHROMA_NUM_W'(sum_b);
      // Both numerators stay positive and below 2^20 for 8-bit channels.
      cb_num_in = ry420_pkg::CB_KB * sb + ry420_pkg::CHROMA_OFS
                - ry420_pkg::CB_KG * sg - ry420_pkg::CB_KR * sr;
      cr_num_in = ry420_pkg::CR_KR * sr + ry420_pkg::CHROMA_OFS
                - ry420_pkg::CR_KG * sg - ry420_pkg::CR_KB * sb;
      cb_prod_in = ry420_pkg::CHROMA_PROD_W'(cb_num_ff)
                 * ry420_pkg::CHROMA_PROD_W'(ry420_pkg::CHROMA_RECIP);
      cr_prod_in = ry420_pkg::CHROMA_PROD_W'(cr_num_ff)
                 * ry420_pkg::CHROMA_PROD_W'(ry420_pkg::CHROMA_RECIP);
   end

   always_ff @(posedge clock) begin
      cb_num_ff  <= cb_num_in;
      cr_num_ff  <= cr_num_in;
      cb_prod_ff <= cb_prod_in;
      cr_prod_ff <= cr_prod_in;
   end

   assign cb_prod = cb_prod_ff;
   assign cr_prod = cr_prod_ff;

endmodule
